// ----- sv/tva_pkg.sv -----
// ----------------------------------------------------------------------------
// tva_pkg
// Shared types and constants for the timestamp arithmetic pipeline.
// ----------------------------------------------------------------------------
package tva_pkg;

  typedef enum logic [1:0] {
    MODE_NORM = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_DIV  = 2'd3
  } mode_t;

  localparam int unsigned DIV64_STEPS = 64;
  localparam int unsigned DIV32_STEPS = 32;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  // floor(2^40 / 15625), 15625 * 64 = 1000000
  localparam logic [26:0] RECIP_15625  = 27'd70368744;

  typedef struct packed {
    logic               dz;
    logic               is_div;
    logic               a_neg;
    logic               d_neg;
    logic [63:0]        sec_pre;
    logic signed [32:0] usec_pre;
  } side1_t;

  typedef struct packed {
    logic               dz;
    logic               is_div;
    logic               d_neg;
    logic               n_neg;
    logic [63:0]        sec;
    logic signed [32:0] usec_pre;
  } side2_t;

  typedef struct packed {
    logic               dz;
    logic [63:0]        sec;
    logic signed [33:0] usec;
  } norm_in_t;

endpackage

// ----- sv/tva_div64.sv -----
// ----------------------------------------------------------------------------
// tva_div64
// Pipelined restoring divider, 64-bit magnitude by 32-bit magnitude,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module tva_div64 import tva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] in_num,
  input  logic [31:0] in_den,
  input  side1_t      in_side,
  output logic        out_vld,
  output logic [63:0] out_quo,
  output logic [31:0] out_rem,
  output logic [31:0] out_den,
  output side1_t      out_side
);

  logic        vld_r  [DIV64_STEPS];
  logic [31:0] rem_r  [DIV64_STEPS];
  logic [63:0] num_r  [DIV64_STEPS];
  logic [31:0] den_r  [DIV64_STEPS];
  side1_t      side_r [DIV64_STEPS];

  for (genvar i = 0; i < DIV64_STEPS; i++) begin : g_stage
    logic        vld_in;
    logic [31:0] rem_in;
    logic [63:0] num_in;
    logic [31:0] den_in;
    side1_t      side_in;
    logic [32:0] trial;
    logic        fits;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign num_in  = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign num_in  = num_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign trial = {rem_in, num_in[63]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= fits ? 32'(trial - {1'b0, den_in}) : trial[31:0];
      num_r[i]  <= {num_in[62:0], fits};
      den_r[i]  <= den_in;
      side_r[i] <= side_in;
    end
  end

  assign out_vld  = vld_r[DIV64_STEPS-1];
  assign out_quo  = num_r[DIV64_STEPS-1];
  assign out_rem  = rem_r[DIV64_STEPS-1];
  assign out_den  = den_r[DIV64_STEPS-1];
  assign out_side = side_r[DIV64_STEPS-1];

endmodule

// ----- sv/tva_div32.sv -----
// ----------------------------------------------------------------------------
// tva_div32
// Pipelined restoring divider for the microsecond carry: 52-bit magnitude
// whose quotient fits 32 bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tva_div32 import tva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [51:0] in_num,
  input  logic [31:0] in_den,
  input  side2_t      in_side,
  output logic        out_vld,
  output logic [31:0] out_quo,
  output side2_t      out_side
);

  logic        vld_r  [DIV32_STEPS];
  logic [31:0] rem_r  [DIV32_STEPS];
  logic [31:0] num_r  [DIV32_STEPS];
  logic [31:0] den_r  [DIV32_STEPS];
  side2_t      side_r [DIV32_STEPS];

  for (genvar i = 0; i < DIV32_STEPS; i++) begin : g_stage
    logic        vld_in;
    logic [31:0] rem_in;
    logic [31:0] num_in;
    logic [31:0] den_in;
    side2_t      side_in;
    logic [32:0] trial;
    logic        fits;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = {12'd0, in_num[51:32]};
      assign num_in  = in_num[31:0];
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign num_in  = num_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign trial = {rem_in, num_in[31]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= fits ? 32'(trial - {1'b0, den_in}) : trial[31:0];
      num_r[i]  <= {num_in[30:0], fits};
      den_r[i]  <= den_in;
      side_r[i] <= side_in;
    end
  end

  assign out_vld  = vld_r[DIV32_STEPS-1];
  assign out_quo  = num_r[DIV32_STEPS-1];
  assign out_side = side_r[DIV32_STEPS-1];

endmodule

// ----- sv/tva_norm.sv -----
// ----------------------------------------------------------------------------
// tva_norm
// Four-stage normalizer: fold signed microseconds into seconds so the
// result microseconds lie in 0..999999; a divide-by-zero item gives zero.
// ----------------------------------------------------------------------------
module tva_norm import tva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  norm_in_t    in_item,
  output logic        out_vld,
  output logic [63:0] out_sec,
  output logic [19:0] out_usec,
  output logic        out_status
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        dz1_r, dz2_r, dz3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [63:0] sec1_r, sec2_r, sec3_r;
  logic [32:0] mag1_r;
  logic [53:0] prod1_r;
  logic [13:0] q2_r, q3_r;
  logic [20:0] rem2_r;
  logic [19:0] rem3_r;
  logic [63:0] sec4_r;
  logic [19:0] usec4_r;
  logic        st4_r;

  logic [33:0] mag_full;
  logic [32:0] mag1_nxt;
  logic [13:0] qest;
  logic [32:0] qprod;
  logic [32:0] rem_full;
  logic        ge;
  logic [13:0] q3_nxt;
  logic [19:0] rem3_nxt;
  logic        borrow;
  logic [63:0] sec4_nxt;
  logic [19:0] usec4_nxt;

  assign mag_full = in_item.usec[33] ? 34'(-in_item.usec) : 34'(in_item.usec);
  assign mag1_nxt = mag_full[32:0];

  assign qest     = prod1_r[53:40];
  assign qprod    = 33'(qest * USEC_PER_SEC);
  assign rem_full = mag1_r - qprod;

  assign ge       = rem2_r >= {1'b0, USEC_PER_SEC};
  assign q3_nxt   = ge ? 14'(q2_r + 14'd1) : q2_r;
  assign rem3_nxt = ge ? 20'(rem2_r - {1'b0, USEC_PER_SEC}) : rem2_r[19:0];

  always_comb begin
    borrow = neg3_r && (rem3_r != '0);
    if (!neg3_r) begin
      sec4_nxt  = sec3_r + {50'd0, q3_r};
      usec4_nxt = rem3_r;
    end else begin
      sec4_nxt  = sec3_r - {50'd0, q3_r} - {63'd0, borrow};
      usec4_nxt = borrow ? 20'(USEC_PER_SEC - rem3_r) : '0;
    end
    if (dz3_r) begin
      sec4_nxt  = '0;
      usec4_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    dz1_r   <= in_item.dz;
    neg1_r  <= in_item.usec[33];
    sec1_r  <= in_item.sec;
    mag1_r  <= mag1_nxt;
    prod1_r <= 54'(mag1_nxt[32:6] * RECIP_15625);

    dz2_r   <= dz1_r;
    neg2_r  <= neg1_r;
    sec2_r  <= sec1_r;
    q2_r    <= qest;
    rem2_r  <= rem_full[20:0];

    dz3_r   <= dz2_r;
    neg3_r  <= neg2_r;
    sec3_r  <= sec2_r;
    q3_r    <= q3_nxt;
    rem3_r  <= rem3_nxt;

    sec4_r  <= sec4_nxt;
    usec4_r <= usec4_nxt;
    st4_r   <= dz3_r;
  end

  assign out_vld    = v4_r;
  assign out_sec    = sec4_r;
  assign out_usec   = usec4_r;
  assign out_status = st4_r;

endmodule

// ----- sv/timeval_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// timeval_arithmetic_unit
// Seconds/microseconds timestamp arithmetic: normalize, add, subtract and
// divide by a signed integer, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_mode and the operands with start high; the item is taken at
//   that clock edge. busy is always low, so an item can enter every cycle.
//   Each item passes 104 register stages; the first loads at the accepting
//   edge, and its result is shown for one cycle with out_valid high:
//   out_res_sec, out_res_usec (0..999999) and out_status (high on divide
//   by zero, with zero result).
//   The register stages are those of the bit-serial pipelined dividers:
//   64 stages for the seconds quotient and 32 for the microsecond carry,
//   plus input, multiply, sign, normalizer input and four normalize stages.
//   Throughput: one item per cycle.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module timeval_arithmetic_unit import tva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_a_sec,
  input  logic [31:0] in_a_usec,
  input  logic [63:0] in_b_sec,
  input  logic [31:0] in_b_usec,
  input  logic [31:0] in_divisor,
  output logic        out_valid,
  output logic [63:0] out_res_sec,
  output logic [19:0] out_res_usec,
  output logic        out_status
);

  logic        v0_r;
  logic [63:0] amag0_r;
  logic [31:0] dmag0_r;
  side1_t      side0_r;
  side1_t      side0_nxt;

  logic        d1_vld;
  logic [63:0] d1_quo;
  logic [31:0] d1_rem;
  logic [31:0] d1_den;
  side1_t      d1_side;

  logic        v1_r;
  logic [51:0] prod1_r;
  logic [31:0] den1_r;
  side2_t      side1_r;
  logic [63:0] secq;

  logic        v2_r;
  logic [51:0] nmag2_r;
  logic [31:0] den2_r;
  side2_t      side2_r;
  side2_t      side2_nxt;
  logic [52:0] n2;
  logic [52:0] nmag_full;

  logic        d2_vld;
  logic [31:0] d2_quo;
  side2_t      d2_side;

  logic        v3_r;
  norm_in_t    nin3_r;
  norm_in_t    nin3_nxt;

  logic signed [32:0] ausec_x;
  logic signed [32:0] busec_x;

  assign busy = 1'b0;

  assign ausec_x = {in_a_usec[31], in_a_usec};
  assign busec_x = {in_b_usec[31], in_b_usec};

  always_comb begin
    side0_nxt.dz     = (mode_t'(in_mode) == MODE_DIV) && (in_divisor == '0);
    side0_nxt.is_div = mode_t'(in_mode) == MODE_DIV;
    side0_nxt.a_neg  = in_a_sec[63];
    side0_nxt.d_neg  = in_divisor[31];
    case (mode_t'(in_mode))
      MODE_ADD: begin
        side0_nxt.sec_pre  = in_a_sec + in_b_sec;
        side0_nxt.usec_pre = ausec_x + busec_x;
      end
      MODE_SUB: begin
        side0_nxt.sec_pre  = in_a_sec - in_b_sec;
        side0_nxt.usec_pre = ausec_x - busec_x;
      end
      default: begin
        side0_nxt.sec_pre  = in_a_sec;
        side0_nxt.usec_pre = ausec_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= d1_vld;
      v2_r <= v1_r;
      v3_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    amag0_r <= in_a_sec[63] ? -in_a_sec : in_a_sec;
    dmag0_r <= in_divisor[31] ? -in_divisor : in_divisor;
    side0_r <= side0_nxt;
  end

  tva_div64 u_div64 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v0_r),
    .in_num   (amag0_r),
    .in_den   (dmag0_r),
    .in_side  (side0_r),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_rem  (d1_rem),
    .out_den  (d1_den),
    .out_side (d1_side)
  );

  assign secq = (d1_side.a_neg ^ d1_side.d_neg) ? -d1_quo : d1_quo;

  always_ff @(posedge clk) begin
    prod1_r          <= 52'(d1_rem * USEC_PER_SEC);
    den1_r           <= d1_den;
    side1_r.dz       <= d1_side.dz;
    side1_r.is_div   <= d1_side.is_div;
    side1_r.d_neg    <= d1_side.d_neg;
    side1_r.n_neg    <= d1_side.a_neg;
    side1_r.sec      <= d1_side.is_div ? secq : d1_side.sec_pre;
    side1_r.usec_pre <= d1_side.usec_pre;
  end

  assign n2 = (side1_r.n_neg ? -{1'b0, prod1_r} : {1'b0, prod1_r})
            + {{20{side1_r.usec_pre[32]}}, side1_r.usec_pre};
  assign nmag_full = n2[52] ? -n2 : n2;

  always_comb begin
    side2_nxt       = side1_r;
    side2_nxt.n_neg = n2[52];
  end

  always_ff @(posedge clk) begin
    nmag2_r <= nmag_full[51:0];
    den2_r  <= den1_r;
    side2_r <= side2_nxt;
  end

  tva_div32 u_div32 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v2_r),
    .in_num   (nmag2_r),
    .in_den   (den2_r),
    .in_side  (side2_r),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  always_comb begin
    nin3_nxt.dz  = d2_side.dz;
    nin3_nxt.sec = d2_side.sec;
    if (d2_side.is_div) begin
      nin3_nxt.usec = (d2_side.n_neg ^ d2_side.d_neg) ? -{2'b00, d2_quo} : {2'b00, d2_quo};
    end else begin
      nin3_nxt.usec = {d2_side.usec_pre[32], d2_side.usec_pre};
    end
  end

  always_ff @(posedge clk) begin
    nin3_r <= nin3_nxt;
  end

  tva_norm u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (v3_r),
    .in_item    (nin3_r),
    .out_vld    (out_valid),
    .out_sec    (out_res_sec),
    .out_usec   (out_res_usec),
    .out_status (out_status)
  );

  a_usec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res_usec < USEC_PER_SEC))
    else $error("result microseconds out of range");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_res_sec == '0 && out_res_usec == '0))
    else $error("divide by zero result not zero");

  a_dz_source: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && nin3_r.dz) |-> ##4 (out_valid && out_status))
    else $error("divide by zero status lost in normalizer");

endmodule
